// ===== src/irfp_pkg.sv =====
`default_nettype none
package irfp_pkg;

    localparam int DEF_MAX_RECORDS     = 32;
    localparam int DEF_MAX_FRAME_BYTES = 1024;

    localparam int MIN_FRAME = 20;
    localparam int COUNT_POS = 17;
    localparam int ID_LEN    = 12;
    localparam int POS_W     = 11;
    localparam int REC_W     = 7;
    localparam int OFS_W     = 5;
    localparam int SUM_W     = 24;

    localparam logic [47:0]      ID_PREFIX_LONG  = 48'h594331303030;
    localparam logic [23:0]      ID_PREFIX_SHORT = 24'h515432;
    localparam logic [SUM_W-1:0] SUM_MAX         = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_OK      = 2'd1,
        KIND_SHORT   = 2'd2,
        KIND_BAD_HDR = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [REC_W-1:0]     slot;
        logic [47:0]          uid_head;
        logic [47:0]          uid_tail;
        logic                 online;
        logic [2:0]           channel_count;
        logic [63:0]          channel_powers;
        logic [63:0]          channel_voltages;
        logic [15:0]          frequency;
        logic signed [15:0]   temperature;
        logic [SUM_W-1:0]     total_power;
        logic                 last;
    } t_result;

    // Expected header byte at frame positions zero to two.
    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h41;
            2'd1:    r = 8'h50;
            2'd2:    r = 8'h53;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/irfp_if.sv =====
`default_nettype none
interface irfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, data_byte, final_byte, input ready);
    modport sink   (input valid, data_byte, final_byte, output ready);
endinterface

interface irfp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [6:0]         slot;
    logic [47:0]        uid_head;
    logic [47:0]        uid_tail;
    logic               online;
    logic [2:0]         channel_count;
    logic [63:0]        channel_powers;
    logic [63:0]        channel_voltages;
    logic [15:0]        frequency;
    logic signed [15:0] temperature;
    logic [23:0]        total_power;
    logic               last;

    modport source (output valid, kind, slot, uid_head, uid_tail, online, channel_count,
                    channel_powers, channel_voltages, frequency, temperature,
                    total_power, last, input ready);
    modport sink   (input valid, kind, slot, uid_head, uid_tail, online, channel_count,
                    channel_powers, channel_voltages, frequency, temperature,
                    total_power, last, output ready);
    modport mon    (input valid, ready, kind, slot, uid_head, uid_tail, online,
                    channel_count, channel_powers, channel_voltages, frequency,
                    temperature, total_power, last);
endinterface
`default_nettype wire

// ===== src/inverter_report_frame_parser.sv =====
// Channel  Dir  Payload                                      Notes
// i_in     in   data_byte, final_byte                        one frame byte per request
// o_out    out  kind, slot, uid, online, channels, freq,     record or summary request,
//               temperature, total_power, last               up to two per input byte
//
// Each byte is parsed in the cycle it is accepted; its results are registered into a
// four-entry output queue before they appear on o_out.
// A byte can be taken every cycle while the queue has room for two results, so a
// sustained rate of one byte per cycle holds as long as o_out drains.
// Reset is synchronous and active low; it clears the parser and empties the queue.
// A stalled o_out holds its request stable and backs up into i_in.ready.
`default_nettype none
module inverter_report_frame_parser
    import irfp_pkg::*;
#(
    parameter int MAX_RECORDS     = DEF_MAX_RECORDS,
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    irfp_in_if.sink    i_in,
    irfp_out_if.source o_out
);

    logic       take;
    logic       room2;
    logic [1:0] push_count;
    t_result    res0;
    t_result    res1;
    t_result    head;

    assign i_in.ready = room2;
    assign take       = i_in.valid && room2;

    irfp_core #(
        .MAX_RECORDS     (MAX_RECORDS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_in.data_byte),
        .i_final (i_in.final_byte),
        .o_count (push_count),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    irfp_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_push0      (res0),
        .i_push1      (res1),
        .i_pop        (o_out.ready),
        .o_room2      (room2),
        .o_valid      (o_out.valid),
        .o_head       (head)
    );

    assign o_out.kind             = head.kind;
    assign o_out.slot             = head.slot;
    assign o_out.uid_head         = head.uid_head;
    assign o_out.uid_tail         = head.uid_tail;
    assign o_out.online           = head.online;
    assign o_out.channel_count    = head.channel_count;
    assign o_out.channel_powers   = head.channel_powers;
    assign o_out.channel_voltages = head.channel_voltages;
    assign o_out.frequency        = head.frequency;
    assign o_out.temperature      = head.temperature;
    assign o_out.total_power      = head.total_power;
    assign o_out.last             = head.last;

endmodule
`default_nettype wire

// ===== src/irfp_core.sv =====
`default_nettype none
module irfp_core
    import irfp_pkg::*;
#(
    parameter int MAX_RECORDS     = DEF_MAX_RECORDS,
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_data,
    input  wire logic       i_final,
    output logic [1:0]      o_count,
    output t_result         o_res0,
    output t_result         o_res1
);

    logic [POS_W-1:0] r_pos,    n_pos;
    logic             r_hdr,    n_hdr;
    logic [REC_W-1:0] r_total,  n_total;
    logic [REC_W-1:0] r_recnum, n_recnum;
    logic [OFS_W-1:0] r_ofs,    n_ofs;
    logic [47:0]      r_id0,    n_id0;
    logic [47:0]      r_id1,    n_id1;
    logic             r_online, n_online;
    logic             r_four,   n_four;
    logic [63:0]      r_pw,     n_pw;
    logic [63:0]      r_vw,     n_vw;
    logic [31:0]      r_ft,     n_ft;
    logic [7:0]       r_pend,   n_pend;
    logic [SUM_W-1:0] r_sum,    n_sum;
    logic             r_low,    n_low;

    logic             active;
    logic             rec_en;
    logic             rec_done;
    logic [15:0]      word;
    logic [OFS_W-1:0] widx;
    logic [OFS_W-1:0] vidx;
    logic [2:0]       nch;
    logic [SUM_W:0]   sum_wide;
    t_result          rec_res;
    t_result          sum_res;

    always_comb begin
        n_pos    = r_pos;
        n_hdr    = r_hdr;
        n_total  = r_total;
        n_recnum = r_recnum;
        n_ofs    = r_ofs;
        n_id0    = r_id0;
        n_id1    = r_id1;
        n_online = r_online;
        n_four   = r_four;
        n_pw     = r_pw;
        n_vw     = r_vw;
        n_ft     = r_ft;
        n_pend   = r_pend;
        n_sum    = r_sum;
        n_low    = r_low;
        rec_done = 1'b0;
        word     = {r_pend, i_data};
        widx     = r_ofs - OFS_W'(ID_LEN + 1);
        nch      = r_four ? 3'd4 : 3'd2;
        vidx     = widx - OFS_W'(nch);
        sum_wide = {1'b0, r_sum} + (SUM_W + 1)'(word);

        active = r_pos < POS_W'(MAX_FRAME_BYTES);
        rec_en = active && (r_pos > POS_W'(COUNT_POS)) && r_hdr && (r_recnum < r_total);

        if (active) begin
            n_pos = r_pos + POS_W'(1);
            if ((r_pos < POS_W'(3)) && (i_data != hdr_byte(r_pos[1:0]))) begin
                n_hdr = 1'b0;
            end
            if (r_pos == POS_W'(COUNT_POS)) begin
                n_total = (i_data > 8'(MAX_RECORDS)) ? REC_W'(MAX_RECORDS) : REC_W'(i_data);
            end
        end

        if (rec_en) begin
            // A record starts from a clean slate at its first byte.
            if (r_ofs == '0) begin
                n_id0    = '0;
                n_id1    = '0;
                n_online = 1'b0;
                n_four   = 1'b0;
                n_pw     = '0;
                n_vw     = '0;
                n_ft     = '0;
                n_low    = 1'b0;
            end
            if (r_ofs < OFS_W'(ID_LEN)) begin
                if (r_ofs < OFS_W'(6)) begin
                    n_id0 = {n_id0[39:0], i_data};
                end else begin
                    n_id1 = {n_id1[39:0], i_data};
                end
                if (r_ofs == OFS_W'(ID_LEN - 1)) begin
                    n_four = (r_id0 == ID_PREFIX_LONG) || (r_id0[47:24] == ID_PREFIX_SHORT);
                end
                n_ofs = r_ofs + OFS_W'(1);
            end else if (r_ofs == OFS_W'(ID_LEN)) begin
                n_online = (i_data == 8'd1);
                n_ofs    = r_ofs + OFS_W'(1);
                n_low    = 1'b0;
            end else if (!r_low) begin
                n_pend = i_data;
                n_low  = 1'b1;
            end else begin
                n_low = 1'b0;
                n_ofs = r_ofs + OFS_W'(1);
                if (widx < OFS_W'(nch)) begin
                    n_pw[16*widx[1:0] +: 16] = word;
                    n_sum = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                end else if (widx < OFS_W'(2 * nch)) begin
                    n_vw[16*vidx[1:0] +: 16] = word;
                end else if (widx == OFS_W'(2 * nch)) begin
                    n_ft[31:16] = word;
                end else begin
                    n_ft[15:0] = word;
                    rec_done   = 1'b1;
                    n_recnum   = r_recnum + REC_W'(1);
                    n_ofs      = '0;
                end
            end
        end

        rec_res                  = '0;
        rec_res.kind             = KIND_RECORD;
        rec_res.slot             = r_recnum;
        rec_res.uid_head         = r_id0;
        rec_res.uid_tail         = r_id1;
        rec_res.online           = r_online;
        rec_res.channel_count    = nch;
        rec_res.channel_powers   = r_pw;
        rec_res.channel_voltages = n_vw;
        rec_res.frequency        = r_ft[31:16];
        rec_res.temperature      = word;
        rec_res.last             = !i_final;

        sum_res      = '0;
        sum_res.last = 1'b1;
        if (n_pos < POS_W'(MIN_FRAME)) begin
            sum_res.kind = KIND_SHORT;
        end else if (!n_hdr) begin
            sum_res.kind = KIND_BAD_HDR;
        end else begin
            sum_res.kind        = KIND_OK;
            sum_res.slot        = n_total;
            sum_res.total_power = n_sum;
        end

        if (rec_done) begin
            o_res0 = rec_res;
            o_res1 = sum_res;
        end else begin
            o_res0 = sum_res;
            o_res1 = sum_res;
        end
        o_count = i_take ? (2'(rec_done) + 2'(i_final)) : 2'd0;

        // The summary closes the frame and the parser starts over.
        if (i_final) begin
            n_pos    = '0;
            n_hdr    = 1'b1;
            n_total  = '0;
            n_recnum = '0;
            n_ofs    = '0;
            n_id0    = '0;
            n_id1    = '0;
            n_online = 1'b0;
            n_four   = 1'b0;
            n_pw     = '0;
            n_vw     = '0;
            n_ft     = '0;
            n_pend   = '0;
            n_sum    = '0;
            n_low    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_hdr    <= 1'b1;
            r_total  <= '0;
            r_recnum <= '0;
            r_ofs    <= '0;
            r_id0    <= '0;
            r_id1    <= '0;
            r_online <= 1'b0;
            r_four   <= 1'b0;
            r_pw     <= '0;
            r_vw     <= '0;
            r_ft     <= '0;
            r_pend   <= '0;
            r_sum    <= '0;
            r_low    <= 1'b0;
        end else if (i_take) begin
            r_pos    <= n_pos;
            r_hdr    <= n_hdr;
            r_total  <= n_total;
            r_recnum <= n_recnum;
            r_ofs    <= n_ofs;
            r_id0    <= n_id0;
            r_id1    <= n_id1;
            r_online <= n_online;
            r_four   <= n_four;
            r_pw     <= n_pw;
            r_vw     <= n_vw;
            r_ft     <= n_ft;
            r_pend   <= n_pend;
            r_sum    <= n_sum;
            r_low    <= n_low;
        end
    end

endmodule
`default_nettype wire

// ===== src/irfp_outq.sv =====
`default_nettype none
module irfp_outq
    import irfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_count,
    input  wire t_result    i_push0,
    input  wire t_result    i_push1,
    input  wire logic       i_pop,
    output logic            o_room2,
    output logic            o_valid,
    output t_result         o_head
);

    localparam int DEPTH = 4;

    t_result    r_mem [DEPTH];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0] r_count,  n_count;
    logic [1:0] wr_next;

    assign o_valid = r_count != 3'd0;
    assign o_head  = r_mem[r_rd_ptr];
    // Room for two requests is checked before this cycle's pop is counted.
    assign o_room2 = r_count <= 3'(DEPTH - 2);
    assign wr_next = r_wr_ptr + 2'd1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + i_push_count;
        n_rd_ptr = r_rd_ptr + 2'(i_pop && o_valid);
        n_count  = r_count + 3'(i_push_count) - 3'(i_pop && o_valid);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_next] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// ===== src/irfp_check.sv =====
`default_nettype none
module irfp_check
    import irfp_pkg::*;
(
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    irfp_out_if.source i_out
);

    // Every summary closes the results of its byte.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && (i_out.kind != KIND_RECORD) |-> i_out.last)
        else $error("summary request without last");

    // A failed frame reports neither a count nor a power total.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && ((i_out.kind == KIND_SHORT) || (i_out.kind == KIND_BAD_HDR))
        |-> (i_out.slot == 7'd0) && (i_out.total_power == 24'd0))
        else $error("failed summary carries count or total");

    // Records carry a two or four channel count and no total.
    a_record_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && (i_out.kind == KIND_RECORD)
        |-> ((i_out.channel_count == 3'd2) || (i_out.channel_count == 3'd4))
            && (i_out.total_power == 24'd0))
        else $error("malformed record request");

    // A two-channel record leaves the upper channel slots empty.
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && (i_out.kind == KIND_RECORD) && (i_out.channel_count == 3'd2)
        |-> (i_out.channel_powers[63:32] == 32'd0) && (i_out.channel_voltages[63:32] == 32'd0))
        else $error("unused channel slot not zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out.valid && !i_out.ready |=> i_out.valid && $stable(i_out.kind)
            && $stable(i_out.slot) && $stable(i_out.total_power) && $stable(i_out.last))
        else $error("stalled request changed");

endmodule

bind inverter_report_frame_parser irfp_check u_irfp_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_out   (o_out)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irfp_pkg::*;

    localparam int          MAX_REC    = DEF_MAX_RECORDS;
    localparam int          MAX_BYTES  = DEF_MAX_FRAME_BYTES;
    localparam logic [23:0] FRAME_HDR  = 24'h415053;
    localparam int          RANDOM_LEN = 900;
    localparam int          HOLD_LEN   = 400;
    // About 950 bytes; each can wait through sender gaps, output stalls and the long hold.
    localparam int          LIMIT      = 200000;

    class report_scoreboard;
        logic [POS_W-1:0] byte_pos;
        logic             hdr_ok;
        logic [REC_W-1:0] rec_count;
        logic [REC_W-1:0] rec_idx;
        logic [OFS_W-1:0] field_idx;
        logic [47:0]      uid [2];
        logic             on_flag;
        logic             quad;
        logic [63:0]      pwr;
        logic [63:0]      volt;
        logic [15:0]      freq;
        logic [15:0]      temp;
        logic [7:0]       hi_byte;
        logic             lo_due;
        logic [SUM_W-1:0] psum;
        t_result          expected_reports[$];
        int               errors;

        function new();
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            hdr_ok    = 1'b1;
            rec_count = '0;
            rec_idx   = '0;
            field_idx = '0;
            uid[0]    = '0;
            uid[1]    = '0;
            on_flag   = 1'b0;
            quad      = 1'b0;
            pwr       = '0;
            volt      = '0;
            freq      = '0;
            temp      = '0;
            hi_byte   = '0;
            lo_due    = 1'b0;
            psum      = '0;
        endfunction

        function void note_byte(logic [7:0] b, logic fin);
            t_result          res [2];
            int               n;
            int               p;
            int               w;
            int               nch;
            logic [15:0]      word;
            logic [SUM_W:0]   wide_sum;
            n = 0;
            if (byte_pos < MAX_BYTES) begin
                p = int'(byte_pos);
                byte_pos = byte_pos + 1'b1;
                if (p < 3 && b != FRAME_HDR[23 - 8*p -: 8])
                    hdr_ok = 1'b0;
                if (p == COUNT_POS)
                    rec_count = (b > MAX_REC) ? REC_W'(MAX_REC) : REC_W'(b);
                if (p > COUNT_POS && hdr_ok && rec_idx < rec_count) begin
                    if (field_idx == 0) begin
                        uid[0]  = '0;
                        uid[1]  = '0;
                        on_flag = 1'b0;
                        quad    = 1'b0;
                        pwr     = '0;
                        volt    = '0;
                        freq    = '0;
                        temp    = '0;
                        lo_due  = 1'b0;
                    end
                    if (field_idx < ID_LEN) begin
                        if (field_idx < 6)
                            uid[0] = {uid[0][39:0], b};
                        else
                            uid[1] = {uid[1][39:0], b};
                        if (field_idx == ID_LEN - 1)
                            quad = (uid[0] == ID_PREFIX_LONG) ||
                                   (uid[0][47:24] == ID_PREFIX_SHORT);
                        field_idx = field_idx + 1'b1;
                    end else if (field_idx == ID_LEN) begin
                        on_flag   = (b == 8'd1);
                        lo_due    = 1'b0;
                        field_idx = field_idx + 1'b1;
                    end else if (!lo_due) begin
                        hi_byte = b;
                        lo_due  = 1'b1;
                    end else begin
                        lo_due = 1'b0;
                        word   = {hi_byte, b};
                        w      = int'(field_idx) - (ID_LEN + 1);
                        nch    = quad ? 4 : 2;
                        if (w < nch) begin
                            pwr[16*w +: 16] = word;
                            wide_sum = psum + word;
                            psum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
                        end else if (w < 2*nch) begin
                            volt[16*(w-nch) +: 16] = word;
                        end else if (w == 2*nch) begin
                            freq = word;
                        end else begin
                            temp = word;
                        end
                        if (w > 2*nch) begin
                            res[n]                  = '0;
                            res[n].kind             = KIND_RECORD;
                            res[n].slot             = rec_idx;
                            res[n].uid_head         = uid[0];
                            res[n].uid_tail         = uid[1];
                            res[n].online           = on_flag;
                            res[n].channel_count    = 3'(nch);
                            res[n].channel_powers   = pwr;
                            res[n].channel_voltages = volt;
                            res[n].frequency        = freq;
                            res[n].temperature      = temp;
                            n++;
                            rec_idx   = rec_idx + 1'b1;
                            field_idx = '0;
                        end else begin
                            field_idx = field_idx + 1'b1;
                        end
                    end
                end
            end
            if (fin) begin
                res[n] = '0;
                // A short frame is reported as such even when its header is wrong.
                if (byte_pos < MIN_FRAME) begin
                    res[n].kind = KIND_SHORT;
                end else if (!hdr_ok) begin
                    res[n].kind = KIND_BAD_HDR;
                end else begin
                    res[n].kind        = KIND_OK;
                    res[n].slot        = rec_count;
                    res[n].total_power = psum;
                end
                n++;
                clear_frame();
            end
            if (n > 0)
                res[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                expected_reports.push_back(res[i]);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (expected_reports.size() == 0) begin
                $error("result with none expected: kind %0d slot %0d", got.kind, got.slot);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("slot", want.slot, got.slot);
            compare_field("uid_head", want.uid_head, got.uid_head);
            compare_field("uid_tail", want.uid_tail, got.uid_tail);
            compare_field("online", want.online, got.online);
            compare_field("channel_count", want.channel_count, got.channel_count);
            compare_field("channel_powers", want.channel_powers, got.channel_powers);
            compare_field("channel_voltages", want.channel_voltages, got.channel_voltages);
            compare_field("frequency", want.frequency, got.frequency);
            compare_field("temperature", want.temperature, got.temperature);
            compare_field("total_power", want.total_power, got.total_power);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    irfp_in_if  in_if ();
    irfp_out_if out_if ();

    inverter_report_frame_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    report_scoreboard sb = new();

    logic [7:0] frame_q[$];
    int         bytes_sent = 0;
    int         burst_left = 0;
    int         cycles     = 0;
    bit         hold_go    = 1'b0;
    bit         hold_done  = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("inverter_report_frame_parser test failed");
            $finish;
        end
    end

    always @(posedge clk) begin : result_monitor
        t_result seen;
        if (rst_n && out_if.valid && out_if.ready) begin
            seen.kind             = t_kind'(out_if.kind);
            seen.slot             = out_if.slot;
            seen.uid_head         = out_if.uid_head;
            seen.uid_tail         = out_if.uid_tail;
            seen.online           = out_if.online;
            seen.channel_count    = out_if.channel_count;
            seen.channel_powers   = out_if.channel_powers;
            seen.channel_voltages = out_if.channel_voltages;
            seen.frequency        = out_if.frequency;
            seen.temperature      = out_if.temperature;
            seen.total_power      = out_if.total_power;
            seen.last             = out_if.last;
            sb.check_report(seen);
        end
    end

    // Output side: stretches of full readiness, random stalls and a repeating stall
    // mask, plus one long hold-off that backs the block up into its input.
    initial begin : result_receiver
        int         mode;
        int         mode_left;
        int         phase;
        int         hold_left;
        logic [7:0] stall_mask;
        mode       = 0;
        mode_left  = 0;
        phase      = 0;
        hold_left  = HOLD_LEN;
        stall_mask = 8'hFF;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_go && !hold_done) begin
                out_if.ready <= 1'b0;
                hold_left--;
                if (hold_left == 0)
                    hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode       = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                    stall_mask = 8'($urandom) | 8'h01;
                end
                mode_left--;
                phase++;
                case (mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= ($urandom_range(0, 3) != 0);
                    default: out_if.ready <= stall_mask[phase % 8];
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the byte is taken.
    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // Keep the input busy while the receiver is holding off.
            if (hold_go && !hold_done)
                gap = 0;
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.final_byte <= fin;
        do @(posedge clk); while (!in_if.ready);
        sb.note_byte(b, fin);
        bytes_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++)
            send_byte(frame_q[i], i == frame_q.size() - 1);
        frame_q.delete();
    endtask

    // Header plus the filler up to the count byte, seventeen bytes in all.
    task automatic push_header(bit good);
        int         bad_at;
        logic [7:0] h;
        bad_at = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
            h = FRAME_HDR[23 - 8*i -: 8];
            if (!good && i == bad_at)
                h = h ^ 8'($urandom_range(1, 255));
            frame_q.push_back(h);
        end
        repeat (14) frame_q.push_back(8'($urandom));
    endtask

    function automatic logic [15:0] pick_word();
        logic [15:0] v;
        case ($urandom_range(0, 7))
            0:       v = 16'h0000;
            1:       v = 16'hFFFF;
            2:       v = 16'h8000;
            3:       v = 16'h7FFF;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // id_sel: 0 long four-channel prefix, 1 short four-channel prefix,
    // 2 random ID, 3 one bit away from either prefix.
    task automatic push_record(int id_sel);
        logic [47:0] head;
        int          nch;
        case (id_sel)
            0: head = ID_PREFIX_LONG;
            1: head = {ID_PREFIX_SHORT, 24'($urandom)};
            2: head = {32'($urandom), 16'($urandom)};
            default: begin
                if ($urandom_range(0, 1))
                    head = ID_PREFIX_LONG ^ (48'h1 << $urandom_range(0, 47));
                else
                    head = {ID_PREFIX_SHORT ^ (24'h1 << $urandom_range(0, 23)),
                            24'($urandom)};
            end
        endcase
        nch = (head == ID_PREFIX_LONG || head[47:24] == ID_PREFIX_SHORT) ? 4 : 2;
        for (int i = 0; i < 6; i++)
            frame_q.push_back(head[47 - 8*i -: 8]);
        repeat (6) frame_q.push_back(8'($urandom));
        frame_q.push_back($urandom_range(0, 1) ? 8'd1 : 8'($urandom));
        repeat (2*nch + 2) begin
            logic [15:0] v;
            v = pick_word();
            frame_q.push_back(v[15:8]);
            frame_q.push_back(v[7:0]);
        end
    endtask

    task automatic send_random_frame();
        int         shape;
        int         len;
        int         nrec;
        int         mark;
        logic [7:0] cnt;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            len = $urandom_range(1, 19);
            push_header($urandom_range(0, 3) != 0);
            repeat (2) frame_q.push_back(8'($urandom));
            while (frame_q.size() > len)
                void'(frame_q.pop_back());
        end else begin
            push_header(shape != 1);
            case ($urandom_range(0, 9))
                0:       cnt = 8'($urandom_range(MAX_REC, 255));
                1:       cnt = 8'($urandom_range(5, MAX_REC));
                default: cnt = 8'($urandom_range(0, 3));
            endcase
            frame_q.push_back(cnt);
            if (cnt > 4)
                nrec = $urandom_range(0, 3);
            else
                nrec = cnt + (($urandom_range(0, 7) == 0) ? 1 : 0);
            repeat (nrec) push_record($urandom_range(0, 3));
            if (cnt > nrec && $urandom_range(0, 2) == 0) begin
                mark = frame_q.size();
                push_record($urandom_range(0, 3));
                len = $urandom_range(1, frame_q.size() - mark - 1);
                repeat (len) void'(frame_q.pop_back());
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
        end
        send_frame();
    endtask

    initial begin : stimulus
        int start;
        int drain;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'h00;
        in_if.final_byte = 1'b0;
        rst_n            = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A one-byte frame, a good header that stops one byte short, and a bad
        // header at exactly the minimum length.
        frame_q.push_back(FRAME_HDR[23:16]);
        send_frame();
        push_header(1'b1);
        repeat (2) frame_q.push_back(8'($urandom));
        send_frame();
        push_header(1'b0);
        repeat (3) frame_q.push_back(8'($urandom));
        send_frame();

        hold_go = 1'b1;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_LEN)
            send_random_frame();
        in_if.valid <= 1'b0;

        drain = 0;
        while (sb.pending() != 0 && drain < 5000) begin
            @(posedge clk);
            drain++;
        end
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("inverter_report_frame_parser test passed");
        else
            $display("inverter_report_frame_parser test failed");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/irfp_pkg.sv
src/irfp_if.sv
src/irfp_core.sv
src/irfp_outq.sv
src/inverter_report_frame_parser.sv
src/irfp_check.sv
tb/sv/tb.sv
